/* rtl/pidc_pkg.sv */
`timescale 1ns / 1ps

package pidc_pkg;

	// q16.16 signed sample
	typedef logic signed [31:0] q_t;

	localparam q_t Q_MAX = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN = 32'sh8000_0000;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_HALF_KI_T   = 3'd1,
		REG_KD_GAIN     = 3'd2,
		REG_DERIV_DECAY = 3'd3,
		REG_INTEG_MIN   = 3'd4,
		REG_INTEG_MAX   = 3'd5,
		REG_OUT_MIN     = 3'd6,
		REG_OUT_MAX     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		q_t prop_gain;
		q_t half_ki_t;
		q_t kd_gain;
		q_t deriv_decay;
		q_t integ_min;
		q_t integ_max;
		q_t out_min;
		q_t out_max;
	} cfg_t;

	// error stage to term stage
	typedef struct packed {
		logic               valid;
		q_t                 err;
		logic signed [32:0] esum;
		logic signed [32:0] dmeas;
	} err_stage_t;

	// term stage to output stage
	typedef struct packed {
		logic valid;
		q_t   prop;
		q_t   integ;
		q_t   deriv;
	} term_stage_t;

	// saturate a 33-bit difference to 32 bits
	function automatic q_t sat33(input logic signed [32:0] x);
		if (x[32] == x[31]) begin
			return x[31:0];
		end
		return x[32] ? Q_MIN : Q_MAX;
	endfunction

	// saturate a 34-bit sum to 32 bits
	function automatic q_t sat34(input logic signed [33:0] x);
		if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
			return x[31:0];
		end
		return x[33] ? Q_MIN : Q_MAX;
	endfunction

	// q16.16 product, floor of the scaled result, saturated
	function automatic q_t qmul(input q_t a, input logic signed [32:0] b);
		logic signed [64:0] p;
		logic signed [48:0] s;
		p = 65'(a) * 65'(b);
		s = p[64:16];
		if (s[48:31] == {18{s[48]}}) begin
			return s[31:0];
		end
		return s[48] ? Q_MIN : Q_MAX;
	endfunction

	// upper limit tested first, so inverted limits give one of the two
	function automatic q_t clamp34(input logic signed [33:0] x, input q_t lo, input q_t hi);
		if (x > 34'(hi)) begin
			return hi;
		end
		if (x < 34'(lo)) begin
			return lo;
		end
		return x[31:0];
	endfunction

endpackage

/* rtl/pid_controller_step_top.sv */
`timescale 1ns / 1ps

// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------
// input     | in_valid / in_stall       | target_value, measured_value (q16.16)
// result    | out_valid / out_stall     | drive_value (q16.16)
// config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one item accepted per cycle while in_stall is low; its result passes stage 2 and stage 3 to the output register
// the rate is set by the integrator and derivative feedback, each closing within one register
// in the term stage (one product plus a clamped or saturated add)
// reset clears gains and the controller state, and opens all limits to the full range
// the output register plus one skid entry hold results; in_stall rises only once the
// skid entry is occupied, and the whole pipeline then holds until it drains

module pid_controller_step_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] target_value,
	input  logic signed [31:0] measured_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] drive_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	pidc_pkg::cfg_t        cfg;
	pidc_pkg::err_stage_t  s2;
	pidc_pkg::term_stage_t s3;
	logic                  en;

	assign in_stall = !en;

	// configuration registers
	pidc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register and error terms
	pidc_err_stage u_err (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (in_valid),
		.target_value   (target_value),
		.measured_value (measured_value),
		.s2             (s2)
	);

	// products and controller state
	pidc_term_stage u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (cfg),
		.s2     (s2),
		.s3     (s3)
	);

	// output sum, clamp and skid
	pidc_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.s3          (s3),
		.en          (en),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_value (drive_value)
	);

endmodule

/* rtl/pidc_cfg_regs.sv */
`timescale 1ns / 1ps

module pidc_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output pidc_pkg::cfg_t      cfg
);

	pidc_pkg::cfg_t cfg_q;

	// writes always taken
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// register file, limits open after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= '0;
			cfg_q.half_ki_t   <= '0;
			cfg_q.kd_gain     <= '0;
			cfg_q.deriv_decay <= '0;
			cfg_q.integ_min   <= pidc_pkg::Q_MIN;
			cfg_q.integ_max   <= pidc_pkg::Q_MAX;
			cfg_q.out_min     <= pidc_pkg::Q_MIN;
			cfg_q.out_max     <= pidc_pkg::Q_MAX;
		end else if (cfg_valid) begin
			case (pidc_pkg::reg_idx_t'(cfg_index))
				pidc_pkg::REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data;
				pidc_pkg::REG_HALF_KI_T:   cfg_q.half_ki_t   <= cfg_data;
				pidc_pkg::REG_KD_GAIN:     cfg_q.kd_gain     <= cfg_data;
				pidc_pkg::REG_DERIV_DECAY: cfg_q.deriv_decay <= cfg_data;
				pidc_pkg::REG_INTEG_MIN:   cfg_q.integ_min   <= cfg_data;
				pidc_pkg::REG_INTEG_MAX:   cfg_q.integ_max   <= cfg_data;
				pidc_pkg::REG_OUT_MIN:     cfg_q.out_min     <= cfg_data;
				pidc_pkg::REG_OUT_MAX:     cfg_q.out_max     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/pidc_err_stage.sv */
`timescale 1ns / 1ps

module pidc_err_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic signed [31:0]     target_value,
	input  logic signed [31:0]     measured_value,
	output pidc_pkg::err_stage_t   s2
);

	logic               valid_s1;
	pidc_pkg::q_t       tgt_s1;
	pidc_pkg::q_t       meas_s1;
	pidc_pkg::q_t       last_err_q;
	pidc_pkg::q_t       last_meas_q;
	logic               valid_s2;
	pidc_pkg::q_t       err_s2;
	logic signed [32:0] esum_s2;
	logic signed [32:0] dmeas_s2;
	pidc_pkg::q_t       err;
	logic signed [32:0] esum;
	logic signed [32:0] dmeas;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			tgt_s1  <= target_value;
			meas_s1 <= measured_value;
		end
	end

	// error saturated to 32 bits; trapezoid sum and measurement change kept exact at 33 bits
	always_comb begin
		err   = pidc_pkg::sat33(33'(tgt_s1) - 33'(meas_s1));
		esum  = 33'(err) + 33'(last_err_q);
		dmeas = 33'(meas_s1) - 33'(last_meas_q);
	end

	// previous error and measurement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q  <= '0;
			last_meas_q <= '0;
		end else if (en && valid_s1) begin
			last_err_q  <= err;
			last_meas_q <= meas_s1;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			err_s2   <= err;
			esum_s2  <= esum;
			dmeas_s2 <= dmeas;
		end
	end

	assign s2.valid = valid_s2;
	assign s2.err   = err_s2;
	assign s2.esum  = esum_s2;
	assign s2.dmeas = dmeas_s2;

endmodule

/* rtl/pidc_term_stage.sv */
`timescale 1ns / 1ps

module pidc_term_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  pidc_pkg::cfg_t          cfg,
	input  pidc_pkg::err_stage_t    s2,
	output pidc_pkg::term_stage_t   s3
);

	pidc_pkg::q_t       integ_acc_q;
	pidc_pkg::q_t       deriv_acc_q;
	pidc_pkg::q_t       prop;
	pidc_pkg::q_t       integ_inc;
	pidc_pkg::q_t       integ_new;
	pidc_pkg::q_t       deriv_kd;
	pidc_pkg::q_t       deriv_fb;
	logic signed [33:0] deriv_sum;
	pidc_pkg::q_t       deriv_new;
	logic               valid_s3;
	pidc_pkg::q_t       prop_s3;
	pidc_pkg::q_t       integ_s3;
	pidc_pkg::q_t       deriv_s3;

	// proportional, integrator and filtered derivative terms
	always_comb begin
		prop      = pidc_pkg::qmul(cfg.prop_gain, 33'(s2.err));
		integ_inc = pidc_pkg::qmul(cfg.half_ki_t, s2.esum);
		integ_new = pidc_pkg::clamp34(34'(integ_acc_q) + 34'(integ_inc),
			cfg.integ_min, cfg.integ_max);
		deriv_kd  = pidc_pkg::qmul(cfg.kd_gain, s2.dmeas);
		deriv_fb  = pidc_pkg::qmul(cfg.deriv_decay, 33'(deriv_acc_q));
		deriv_sum = 34'(deriv_kd) + 34'(deriv_fb);
		deriv_new = pidc_pkg::sat34(-deriv_sum);
	end

	// integrator and derivative state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_acc_q <= '0;
			deriv_acc_q <= '0;
		end else if (en && s2.valid) begin
			integ_acc_q <= integ_new;
			deriv_acc_q <= deriv_new;
		end
	end

	// stage 3 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= s2.valid;
		end
	end

	// stage 3 payload
	always_ff @(posedge clk) begin
		if (en && s2.valid) begin
			prop_s3  <= prop;
			integ_s3 <= integ_new;
			deriv_s3 <= deriv_new;
		end
	end

	assign s3.valid = valid_s3;
	assign s3.prop  = prop_s3;
	assign s3.integ = integ_s3;
	assign s3.deriv = deriv_s3;

endmodule

/* rtl/pidc_out_stage.sv */
`timescale 1ns / 1ps

module pidc_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pidc_pkg::cfg_t         cfg,
	input  pidc_pkg::term_stage_t  s3,
	output logic                   en,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [31:0]     drive_value
);

	logic         out_valid_q;
	logic         skid_valid_q;
	pidc_pkg::q_t drive_q;
	pidc_pkg::q_t skid_q;
	pidc_pkg::q_t total;
	logic         res_valid;
	logic         take;
	logic         to_out;

	// pipeline moves while the skid entry is free
	assign en        = !skid_valid_q;
	assign res_valid = s3.valid && en;
	assign take      = out_valid_q && !out_stall;
	assign to_out    = !out_valid_q || take;

	// sum of the three terms, clamped to the output limits
	always_comb begin
		total = pidc_pkg::clamp34(34'(s3.prop) + 34'(s3.integ) + 34'(s3.deriv),
			cfg.out_min, cfg.out_max);
	end

	// output register and skid entry control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (to_out) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register and skid entry payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				drive_q <= skid_q;
			end
		end else if (res_valid) begin
			if (to_out) begin
				drive_q <= total;
			end else begin
				skid_q <= total;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;

endmodule

/* rtl/pidc_checker.sv */
`timescale 1ns / 1ps

module pidc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] drive_value
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_value))
		else $error("result changed while stalled");

	// input stalls only with a result waiting
	a_stall_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result shown");

	// input stall starts only after a stalled result
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall began without output back-pressure");

	// input stall ends only after a result was taken
	a_stall_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> $past(out_valid && !out_stall))
		else $error("input stall ended without a result taken");

endmodule

bind pid_controller_step_top pidc_checker u_pidc_checker (.*);
